// File: rtl/rth_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the RGB-to-hue converter.
// No dependencies; every rtl/rth_* module and the top level import it.
package rth_pkg;

    localparam int HUE_FRAC_BITS = 6;

    localparam int CH_W   = 8;
    localparam int PIX_W  = 3 * CH_W;
    localparam int HUE_W  = 15;

    localparam int HUE_SCALE = 60 << HUE_FRAC_BITS;
    localparam int HUE_FULL  = 360 << HUE_FRAC_BITS;

    // quotient of scale * |d| / diff never exceeds HUE_SCALE
    localparam int QUO_W  = $clog2(HUE_SCALE + 1);
    localparam int NUM_W  = QUO_W + CH_W;
    localparam int HSUM_W = QUO_W + 4;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        SECT_RED   = 2'd0,
        SECT_GREEN = 2'd1,
        SECT_BLUE  = 2'd2
    } hue_sect_t;

    typedef struct packed {
        logic             gray;
        logic             neg;
        hue_sect_t        sect;
        logic [NUM_W-1:0] num;
        logic [CH_W-1:0]  den;
    } hue_job_t;

endpackage

// File: rtl/rth_front.sv
`timescale 1ns / 1ps
// Front end: splits a pixel, finds max/min, picks the hue sector and
// builds the scaled dividend and divisor. Depends on rth_pkg.
module rth_front (
    input  logic [rth_pkg::PIX_W-1:0] pixel,
    output rth_pkg::hue_job_t         job
);
    import rth_pkg::*;

    logic [CH_W-1:0] r, g, b;
    logic [CH_W-1:0] mx, mn;
    logic [CH_W-1:0] sub_a, sub_b;
    logic [CH_W-1:0] mag;
    logic            neg;
    hue_sect_t       sect;

    assign r = pixel[3*CH_W-1:2*CH_W];
    assign g = pixel[2*CH_W-1:CH_W];
    assign b = pixel[CH_W-1:0];

    always_comb begin
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;

        if (mx == r) begin
            sect = SECT_RED;
        end else if (mx == g) begin
            sect = SECT_GREEN;
        end else begin
            sect = SECT_BLUE;
        end

        unique case (sect)
            SECT_RED: begin
                sub_a = g;
                sub_b = b;
            end
            SECT_GREEN: begin
                sub_a = b;
                sub_b = r;
            end
            default: begin
                sub_a = r;
                sub_b = g;
            end
        endcase

        neg = (sub_a < sub_b);
        mag = neg ? (sub_b - sub_a) : (sub_a - sub_b);

        job.gray = (mx == mn);
        job.neg  = neg;
        job.sect = sect;
        job.num  = NUM_W'(mag) * NUM_W'(HUE_SCALE);
        job.den  = mx - mn;
    end

endmodule

// File: rtl/rth_queue.sv
`timescale 1ns / 1ps
// Short job queue between front end and divider pipeline.
// Depends on rth_pkg (hue_job_t, Q_DEPTH).
module rth_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  rth_pkg::hue_job_t push_job,
    output logic              pop_valid,
    input  logic              pop_ready,
    output rth_pkg::hue_job_t pop_job
);
    import rth_pkg::*;

    hue_job_t           mem_reg [Q_DEPTH];
    logic [Q_PTR_W:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W:0]   rd_ptr_reg, rd_ptr_next;
    logic               push, pop;

    assign pop_valid  = (wr_ptr_reg != rd_ptr_reg);
    assign push_ready = !((wr_ptr_reg[Q_PTR_W] != rd_ptr_reg[Q_PTR_W]) &&
                          (wr_ptr_reg[Q_PTR_W-1:0] == rd_ptr_reg[Q_PTR_W-1:0]));
    assign push = push_valid && push_ready;
    assign pop  = pop_valid && pop_ready;
    assign pop_job = mem_reg[rd_ptr_reg[Q_PTR_W-1:0]];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) wr_ptr_next = wr_ptr_reg + 1'b1;
        if (pop)  rd_ptr_next = rd_ptr_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg[Q_PTR_W-1:0]] <= push_job;
    end

endmodule

// File: rtl/rth_back.sv
`timescale 1ns / 1ps
// Back end: pipelined restoring divider, one quotient bit per stage,
// then floor correction, sector base, wrap and output register. Depends on rth_pkg.
module rth_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  rth_pkg::hue_job_t         in_job,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [rth_pkg::HUE_W-1:0] m_hue,
    output logic                      m_is_gray
);
    import rth_pkg::*;

    typedef struct packed {
        hue_job_t         job;
        logic [CH_W-1:0]  rem;
        logic [QUO_W-1:0] quo;
    } div_stage_t;

    div_stage_t          stage_reg  [0:QUO_W];
    div_stage_t          stage_next [0:QUO_W];
    logic [QUO_W:0]      stage_vld_reg;
    logic                m_valid_reg;
    logic [HUE_W-1:0]    hue_reg, hue_next;
    logic                gray_reg, gray_next;
    logic                advance;

    logic [QUO_W:0]      quo_fix;
    logic [HSUM_W-1:0]   base;
    logic [HSUM_W-1:0]   h_sum;
    logic [HSUM_W-1:0]   h_wrap;

    assign advance   = !m_valid_reg || m_ready;
    assign in_ready  = advance;
    assign m_valid   = m_valid_reg;
    assign m_hue     = hue_reg;
    assign m_is_gray = gray_reg;

    always_comb begin
        stage_next[0].job = in_job;
        stage_next[0].rem = in_job.num[NUM_W-1:QUO_W];
        stage_next[0].quo = '0;
    end

    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        logic [CH_W:0] trial;
        logic          ge;
        always_comb begin
            trial = {stage_reg[k].rem, stage_reg[k].job.num[QUO_W-1-k]};
            ge    = (trial >= {1'b0, stage_reg[k].job.den});
            stage_next[k+1].job = stage_reg[k].job;
            stage_next[k+1].rem = ge ? CH_W'(trial - {1'b0, stage_reg[k].job.den})
                                     : trial[CH_W-1:0];
            stage_next[k+1].quo = {stage_reg[k].quo[QUO_W-2:0], ge};
        end
    end

    always_comb begin
        quo_fix = (QUO_W+1)'(stage_reg[QUO_W].quo) +
                  (QUO_W+1)'(stage_reg[QUO_W].job.neg && (stage_reg[QUO_W].rem != '0));
        unique case (stage_reg[QUO_W].job.sect)
            SECT_RED:   base = '0;
            SECT_GREEN: base = HSUM_W'(2 * HUE_SCALE);
            SECT_BLUE:  base = HSUM_W'(4 * HUE_SCALE);
            default:    base = '0;
        endcase
        h_sum = stage_reg[QUO_W].job.neg ? (base - HSUM_W'(quo_fix))
                                         : (base + HSUM_W'(quo_fix));
        h_wrap = h_sum[HSUM_W-1] ? (h_sum + HSUM_W'(HUE_FULL)) : h_sum;
        gray_next = stage_reg[QUO_W].job.gray;
        hue_next  = gray_next ? '0 : HUE_W'(h_wrap);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_vld_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else if (advance) begin
            stage_vld_reg <= {stage_vld_reg[QUO_W-1:0], in_valid};
            m_valid_reg   <= stage_vld_reg[QUO_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int i = 0; i <= QUO_W; i++) stage_reg[i] <= stage_next[i];
            hue_reg  <= hue_next;
            gray_reg <= gray_next;
        end
    end

endmodule

// File: rtl/rgb_to_hue.sv
`timescale 1ns / 1ps
// RGB to HSV hue converter, top level. Depends on rth_pkg, rth_front, rth_queue, rth_back.
// Throughput: one pixel per cycle while the output is not stalled;
// the divider pipeline retires one quotient bit per stage.
// Output stall holds the whole divider pipeline; the queue takes up to Q_DEPTH (4) more
// items meanwhile, then s_ready drops until the output drains.
// Synchronous active-low reset empties the queue and clears all pipeline valids.
module rgb_to_hue (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [rth_pkg::PIX_W-1:0] s_pixel_rgb,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [rth_pkg::HUE_W-1:0] m_hue,
    output logic                      m_is_gray
);
    import rth_pkg::*;

    hue_job_t front_job;
    hue_job_t q_job;
    logic     q_valid;
    logic     back_ready;

    rth_front u_front (
        .pixel (s_pixel_rgb),
        .job   (front_job)
    );

    rth_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_valid),
        .push_ready (s_ready),
        .push_job   (front_job),
        .pop_valid  (q_valid),
        .pop_ready  (back_ready),
        .pop_job    (q_job)
    );

    rth_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_ready  (back_ready),
        .in_job    (q_job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_hue     (m_hue),
        .m_is_gray (m_is_gray)
    );

    a_gray_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_gray |-> m_hue == '0)
        else $error("gray item with nonzero hue");

    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> 32'(m_hue) < 32'(HUE_FULL) || HUE_FULL > (1 << HUE_W))
        else $error("hue out of range");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_queue_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_valid |-> s_ready)
        else $error("empty queue refuses an item");

endmodule

// File: tb/tb_rgb_to_hue.sv
`timescale 1ns / 1ps
// Self-checking bench for rgb_to_hue: directed pixel table, then biased random pixels.
// Expected hues: table or in-bench integer floor division. Depends on rth_pkg.
module tb_rgb_to_hue;
    import rth_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RAND_ITEMS   = 830;
    localparam int HOLD_CYCLES  = 200;
    localparam int STALL_LIMIT  = 2000;
    localparam int PIPE_LAT     = QUO_W + 2;
    localparam int DRAIN_CYCLES = 2 * PIPE_LAT + 8;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic             gray;
    } hue_res_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             known;
        logic [HUE_W-1:0] hue;
        logic             gray;
    } pix_row_t;

    typedef enum int {
        PK_ANY,
        PK_GRAY,
        PK_TIE,
        PK_NEAR,
        PK_EDGE
    } pix_kind_t;

    localparam int N_ROWS = 25;

    pix_row_t pixel_table [N_ROWS] = '{
        '{24'h000000, 1'b1, 15'd0,     1'b1},
        '{24'hffffff, 1'b1, 15'd0,     1'b1},
        '{24'h7f7f7f, 1'b1, 15'd0,     1'b1},
        '{24'h010101, 1'b1, 15'd0,     1'b1},
        '{24'hff0000, 1'b1, 15'd0,     1'b0},
        '{24'h00ff00, 1'b1, 15'd7680,  1'b0},
        '{24'h0000ff, 1'b1, 15'd15360, 1'b0},
        '{24'h010000, 1'b1, 15'd0,     1'b0},
        '{24'h000100, 1'b1, 15'd7680,  1'b0},
        '{24'h000001, 1'b1, 15'd15360, 1'b0},
        '{24'hffff00, 1'b1, 15'd3840,  1'b0},
        '{24'h00ffff, 1'b1, 15'd11520, 1'b0},
        '{24'hff00ff, 1'b1, 15'd19200, 1'b0},
        '{24'hff0001, 1'b0, 15'd0,     1'b0},
        '{24'h020001, 1'b0, 15'd0,     1'b0},
        '{24'hff8000, 1'b0, 15'd0,     1'b0},
        '{24'h80ff00, 1'b0, 15'd0,     1'b0},
        '{24'h00ff80, 1'b0, 15'd0,     1'b0},
        '{24'h0080ff, 1'b0, 15'd0,     1'b0},
        '{24'h8000ff, 1'b0, 15'd0,     1'b0},
        '{24'h123456, 1'b0, 15'd0,     1'b0},
        '{24'hfedcba, 1'b0, 15'd0,     1'b0},
        '{24'h000102, 1'b0, 15'd0,     1'b0},
        '{24'h5a5a5b, 1'b0, 15'd0,     1'b0},
        '{24'hfefffe, 1'b0, 15'd0,     1'b0}
    };

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [PIX_W-1:0] s_pixel_rgb;
    logic             m_valid;
    logic             m_ready;
    logic [HUE_W-1:0] m_hue;
    logic             m_is_gray;

    hue_res_t offered_res;
    hue_res_t hue_due_q [$];
    int       mismatch_cnt = 0;
    int       stall_cycles = 0;
    logic     steady       = 1'b0;
    logic     src_eager    = 1'b0;
    logic     hold_req     = 1'b0;

    rgb_to_hue uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixel_rgb (s_pixel_rgb),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hue       (m_hue),
        .m_is_gray   (m_is_gray)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic int floor_quot(input int num, input int den);
        if (num >= 0) begin
            return num / den;
        end
        return -((-num + den - 1) / den);
    endfunction

    function automatic hue_res_t predict_hue(input logic [PIX_W-1:0] px);
        int       r;
        int       g;
        int       b;
        int       mx;
        int       mn;
        int       h;
        hue_res_t res;
        r  = int'(px[3*CH_W-1:2*CH_W]);
        g  = int'(px[2*CH_W-1:CH_W]);
        b  = int'(px[CH_W-1:0]);
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        if (mx == mn) begin
            res.hue  = '0;
            res.gray = 1'b1;
            return res;
        end
        if (mx == r) begin
            h = floor_quot(HUE_SCALE * (g - b), mx - mn);
        end else if (mx == g) begin
            h = 2 * HUE_SCALE + floor_quot(HUE_SCALE * (b - r), mx - mn);
        end else begin
            h = 4 * HUE_SCALE + floor_quot(HUE_SCALE * (r - g), mx - mn);
        end
        if (h < 0) h += HUE_FULL;
        res.hue  = h[HUE_W-1:0];
        res.gray = 1'b0;
        return res;
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel();
        logic [CH_W-1:0] c [3];
        pix_kind_t       kind;
        int              pick;
        int              i;
        pick = $urandom_range(8);
        kind = (pick < 5) ? PK_ANY : pix_kind_t'(pick - 4);
        for (i = 0; i < 3; i++) c[i] = CH_W'($urandom_range(255));
        case (kind)
            PK_GRAY: begin
                c[1] = c[0];
                c[2] = c[0];
            end
            PK_TIE: begin
                i = $urandom_range(2);
                c[(i + 1) % 3] = c[i];
            end
            PK_NEAR: begin
                c[0] = CH_W'($urandom_range(253));
                c[1] = c[0] + CH_W'($urandom_range(2));
                c[2] = c[0] + CH_W'($urandom_range(2));
            end
            PK_EDGE: begin
                for (i = 0; i < 3; i++) begin
                    c[i] = $urandom_range(1) ? CH_W'(255 - $urandom_range(1))
                                             : CH_W'($urandom_range(1));
                end
            end
            default: begin
            end
        endcase
        return {c[0], c[1], c[2]};
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    // hold the item until accepted; optional idle gap ahead of it
    task automatic offer_pixel(input logic [PIX_W-1:0] px, input hue_res_t res);
        if (!steady && !src_eager && $urandom_range(99) < 37) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(2)) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_pixel_rgb <= px;
        offered_res <= res;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : scoreboard
        hue_res_t due;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (hue_due_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected item hue=%0d gray=%0b",
                                              m_hue, m_is_gray));
                end else begin
                    due = hue_due_q.pop_front();
                    if (m_hue !== due.hue) begin
                        report_mismatch($sformatf("hue got %0d want %0d", m_hue, due.hue));
                    end
                    if (m_is_gray !== due.gray) begin
                        report_mismatch($sformatf("is_gray got %0b want %0b",
                                                  m_is_gray, due.gray));
                    end
                end
            end
            if (s_valid && s_ready) hue_due_q = {hue_due_q, offered_res};
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : sink
        int hold_left;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (steady) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 37);
            end
        end
    end

    initial begin : stimulus
        logic [PIX_W-1:0] px;
        hue_res_t         res;
        int               n;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_pixel_rgb = '0;
        offered_res = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (n = 0; n < N_ROWS; n++) begin
            if (pixel_table[n].known) begin
                res.hue  = pixel_table[n].hue;
                res.gray = pixel_table[n].gray;
            end else begin
                res = predict_hue(pixel_table[n].pixel);
            end
            offer_pixel(pixel_table[n].pixel, res);
        end

        for (n = 0; n < RAND_ITEMS; n++) begin
            if (n == 200) steady = 1'b1;
            if (n == 350) steady = 1'b0;
            if (n == 450) begin
                hold_req  = 1'b1;
                src_eager = 1'b1;
            end
            if (n == 520) src_eager = 1'b0;
            if (n == 650) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                while (hue_due_q.size() != 0) @(posedge aclk);
            end
            px = random_pixel();
            offer_pixel(px, predict_hue(px));
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (hue_due_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/rth_pkg.sv
rtl/rth_front.sv
rtl/rth_queue.sv
rtl/rth_back.sv
rtl/rgb_to_hue.sv
tb/tb_rgb_to_hue.sv
